[design/rhbp_pkg.sv]
package rhbp_pkg;

  localparam int unsigned RGB_W  = 24;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned ADDR_W = 13;

  localparam logic [2:0] GROUP_LAST    = 3'd6;
  localparam logic [4:0] PAIR_LAST     = 5'd19;
  localparam logic [7:0] ROW_LAST      = 8'd191;
  localparam logic [6:0] THIRD_STRIDE  = 7'h28;

  // address of the last byte of a frame (row 191, pair 19, odd byte)
  localparam logic [ADDR_W-1:0] FRAME_LAST_ADDR = 13'h1ff7;

  typedef logic [RGB_W-1:0]  rgb_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  found;
    code_t code;
  } lookup_t;

  localparam code_t CODE_BLACK   = 3'd0;
  localparam code_t CODE_MAGENTA = 3'd1;
  localparam code_t CODE_GREEN   = 3'd2;
  localparam code_t CODE_WHITE   = 3'd3;
  localparam code_t CODE_BLUE    = 3'd5;
  localparam code_t CODE_ORANGE  = 3'd6;

  function automatic lookup_t colour_lookup(rgb_t rgb);
    lookup_t res;
    res.found = 1'b1;
    case (rgb)
      24'h000000: res.code = CODE_BLACK;
      24'h1bcb01: res.code = CODE_GREEN;
      24'h14f53c: res.code = CODE_GREEN;
      24'he434fe: res.code = CODE_MAGENTA;
      24'he31e60: res.code = CODE_MAGENTA;
      24'hffffff: res.code = CODE_WHITE;
      24'hcd5b01: res.code = CODE_ORANGE;
      24'hff6a3c: res.code = CODE_ORANGE;
      24'h1b9afe: res.code = CODE_BLUE;
      24'h14cffd: res.code = CODE_BLUE;
      default: begin
        res.found = 1'b0;
        res.code  = CODE_BLACK;
      end
    endcase
    return res;
  endfunction

endpackage

[design/rgb_to_hires_byte_packer_top.sv]
// Packs a raster of 24-bit RGB pixels (280 per row, 192 rows per frame) into
// hires screen bytes. One pixel is taken per clock while in_stall is low;
// every seventh pixel yields a byte with its 13-bit offset in the
// interleaved 8K page, a mixed-palette warning, an unknown-colour flag and a
// frame-end marker. The result sits in an output register, so the first six
// pixels of the next group keep flowing while a byte waits; only the seventh
// pixel of a group is held off while the previous byte is still stalled. The
// byte is valid in the cycle after its seventh pixel is taken. Colour lookup,
// bit gathering and the palette vote are a single pass of logic into the
// group and output registers.
module rgb_to_hires_byte_packer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_pixel_rgb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_screen_byte,
  output logic [12:0] out_screen_address,
  output logic        out_mixed_palette,
  output logic        out_unknown_colour,
  output logic        out_frame_end
);

  logic [2:0] pixel_in_group_r, pixel_in_group_nxt;
  logic       odd_byte_r, odd_byte_nxt;
  logic [4:0] pair_col_r, pair_col_nxt;
  logic [7:0] row_r, row_nxt;
  logic [6:0] bits_r, bits_nxt;
  logic [2:0] high_votes_r, high_votes_nxt;
  logic [2:0] low_votes_r, low_votes_nxt;
  logic       unknown_r, unknown_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [12:0] out_addr_r, out_addr_nxt;
  logic        out_mixed_r, out_mixed_nxt;
  logic        out_unknown_r, out_unknown_nxt;
  logic        out_frame_end_r, out_frame_end_nxt;

  rhbp_pkg::lookup_t lk;
  logic        group_done;
  logic        in_take;
  logic        out_take;
  logic        sel;
  logic        pix_bit;
  logic        vote_hi, vote_lo;
  logic [6:0]  bits_all;
  logic [2:0]  hi_all, lo_all;
  logic        pal;
  logic        mixed;
  logic [12:0] row_base;
  logic [12:0] addr;

  assign group_done = (pixel_in_group_r == rhbp_pkg::GROUP_LAST);
  assign out_take   = out_valid_r && !out_stall;
  // only the group-closing pixel needs a free output slot
  assign in_stall   = group_done && out_valid_r && out_stall;
  assign in_take    = in_valid && !in_stall;

  always_comb begin
    lk      = rhbp_pkg::colour_lookup(in_pixel_rgb);
    sel     = pixel_in_group_r[0] ^ odd_byte_r;
    pix_bit = sel ? lk.code[1] : lk.code[0];
    vote_hi = (lk.code > rhbp_pkg::CODE_GREEN) || (lk.code == rhbp_pkg::CODE_BLACK);
    vote_lo = (lk.code < 3'd4) || (lk.code == 3'd7);

    bits_all = bits_r | (7'(pix_bit) << pixel_in_group_r);
    hi_all   = high_votes_r + 3'(vote_hi);
    lo_all   = low_votes_r + 3'(vote_lo);

    mixed = 1'b0;
    if (hi_all == 3'd7) begin
      pal = 1'b1;
    end else if (lo_all == 3'd7) begin
      pal = 1'b0;
    end else begin
      mixed = 1'b1;
      pal   = (hi_all > lo_all);
    end

    row_base = {row_r[2:0], 10'b0} + {3'b0, row_r[5:3], 7'b0}
             + 13'(row_r[7:6] * rhbp_pkg::THIRD_STRIDE);
    addr     = row_base + {7'b0, pair_col_r, odd_byte_r};

    pixel_in_group_nxt = pixel_in_group_r;
    odd_byte_nxt       = odd_byte_r;
    pair_col_nxt       = pair_col_r;
    row_nxt            = row_r;
    bits_nxt           = bits_r;
    high_votes_nxt     = high_votes_r;
    low_votes_nxt      = low_votes_r;
    unknown_nxt        = unknown_r;

    out_valid_nxt     = out_valid_r && !out_take;
    out_byte_nxt      = out_byte_r;
    out_addr_nxt      = out_addr_r;
    out_mixed_nxt     = out_mixed_r;
    out_unknown_nxt   = out_unknown_r;
    out_frame_end_nxt = out_frame_end_r;

    if (in_take) begin
      if (!group_done) begin
        pixel_in_group_nxt = pixel_in_group_r + 3'd1;
        bits_nxt           = bits_all;
        high_votes_nxt     = hi_all;
        low_votes_nxt      = lo_all;
        unknown_nxt        = unknown_r || !lk.found;
      end else begin
        out_valid_nxt     = 1'b1;
        out_byte_nxt      = {pal, bits_all};
        out_addr_nxt      = addr;
        out_mixed_nxt     = mixed;
        out_unknown_nxt   = unknown_r || !lk.found;
        out_frame_end_nxt = (row_r == rhbp_pkg::ROW_LAST)
                         && (pair_col_r == rhbp_pkg::PAIR_LAST) && odd_byte_r;

        pixel_in_group_nxt = 3'd0;
        bits_nxt           = 7'd0;
        high_votes_nxt     = 3'd0;
        low_votes_nxt      = 3'd0;
        unknown_nxt        = 1'b0;

        odd_byte_nxt = !odd_byte_r;
        if (odd_byte_r) begin
          if (pair_col_r >= rhbp_pkg::PAIR_LAST) begin
            pair_col_nxt = 5'd0;
            row_nxt = (row_r >= rhbp_pkg::ROW_LAST) ? 8'd0 : row_r + 8'd1;
          end else begin
            pair_col_nxt = pair_col_r + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_in_group_r <= 3'd0;
      odd_byte_r       <= 1'b0;
      pair_col_r       <= 5'd0;
      row_r            <= 8'd0;
      bits_r           <= 7'd0;
      high_votes_r     <= 3'd0;
      low_votes_r      <= 3'd0;
      unknown_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      pixel_in_group_r <= pixel_in_group_nxt;
      odd_byte_r       <= odd_byte_nxt;
      pair_col_r       <= pair_col_nxt;
      row_r            <= row_nxt;
      bits_r           <= bits_nxt;
      high_votes_r     <= high_votes_nxt;
      low_votes_r      <= low_votes_nxt;
      unknown_r        <= unknown_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r      <= out_byte_nxt;
    out_addr_r      <= out_addr_nxt;
    out_mixed_r     <= out_mixed_nxt;
    out_unknown_r   <= out_unknown_nxt;
    out_frame_end_r <= out_frame_end_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_screen_byte    = out_byte_r;
  assign out_screen_address = out_addr_r;
  assign out_mixed_palette  = out_mixed_r;
  assign out_unknown_colour = out_unknown_r;
  assign out_frame_end      = out_frame_end_r;

endmodule

[design/rhbp_checker.sv]
module rhbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_screen_address,
  input logic        out_frame_end
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a waiting byte stays until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output dropped while stalled");

  // a byte only appears right after an input transaction closed its group
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("output without input transaction");

  // frame end always lands on the last byte of the page layout
  a_frame_end_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_screen_address == rhbp_pkg::FRAME_LAST_ADDR)
    else $error("frame end at wrong address");

endmodule

bind rgb_to_hires_byte_packer_top rhbp_checker u_rhbp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_screen_address (out_screen_address),
  .out_frame_end      (out_frame_end)
);
